// ===== rtl/core/timestamped_capture_period_duty_macros.svh =====
// Assertion macros for the timestamped capture block.
// Used by the capture top level and its divider; no other dependencies.
`ifndef TIMESTAMPED_CAPTURE_PERIOD_DUTY_MACROS_SVH
`define TIMESTAMPED_CAPTURE_PERIOD_DUTY_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TCPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TCPD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TCPD_ASSERT(lbl, prop, msg)
`define TCPD_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/tcpd_pkg.sv =====
// Shared types and constants for the timestamped capture block.
// No dependencies.
package tcpd_pkg;

	localparam int DEPTH      = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int DVD_W      = 48;
	localparam int DSR_W      = 32;
	localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
	localparam int DUTY_SCALE = 100 * 256;
	localparam int Q_SHIFT    = 8;

	typedef enum logic [2:0] {
		CMD_RECORD     = 3'd0,
		CMD_RECORD_CHG = 3'd1,
		CMD_PERIOD     = 3'd2,
		CMD_DUTY       = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_MUL,
		ST_RATIO_GO,
		ST_RATIO_WAIT,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/timestamped_capture_period_duty.sv =====
// Timestamped capture buffer with period and duty measurement, top level.
// Depends on tcpd_pkg, tcpd_div and the assertion macro header.
//
//  channel | signals                                          | role
//  cmd     | cmd_valid cmd_ready command sample_value          | command in
//          | timestamp bit_mask                                |
//  rsp     | rsp_valid rsp_ready ok measured                   | result out
//
// Record, clear and unused commands leave the sequencer idle: a new one
// is taken every cycle while the result register drains.
// Measure commands walk the store, reading and then evaluating each entry;
// for duty, each closed period of nonzero length adds a multiply and a
// divider run. When a period closed, an averaging divide follows; a
// finish state then ends the walk.
// Reset empties the store by clearing the entry count; no clearing pass.
// cmd_ready is low during a measurement and while the result waits.
`include "timestamped_capture_period_duty_macros.svh"

module timestamped_capture_period_duty
	import tcpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [2:0]        command,
	input  logic [DATA_W-1:0] sample_value,
	input  logic [DATA_W-1:0] timestamp,
	input  logic [DATA_W-1:0] bit_mask,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              ok,
	output logic [DATA_W-1:0] measured
);

	logic [2*DATA_W-1:0] mem [DEPTH];
	logic [2*DATA_W-1:0] rd_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] last_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  n_q;
	logic [DVD_W-1:0]  acc_q;
	logic [DATA_W-1:0] open_q;
	logic [DATA_W-1:0] fall_q;
	logic              seen_rise_q;
	logic              was_low_q;
	logic [DATA_W-1:0] mask_q;
	logic              duty_q;
	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] per_q;
	logic [DVD_W-1:0]  prod_q;

	logic              rsp_valid_q;
	logic              ok_q;
	logic [DATA_W-1:0] measured_q;

	logic              accept;
	logic              is_meas;
	logic              full;
	logic              wr_en;
	logic              rec_ok;
	logic              mem_rd;
	logic              walk_end;

	logic [DATA_W-1:0] rd_value;
	logic [DATA_W-1:0] rd_time;
	logic              high;
	logic              closing;
	logic              opening;
	logic [DATA_W-1:0] per;
	logic [DATA_W-1:0] hi_raw;
	logic [DATA_W-1:0] hi_sat;
	logic              need_div;
	logic [DATA_W-1:0] avg;

	div_req_t div_req;
	div_rsp_t div_rsp;

	tcpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// per-entry evaluation
	always_comb begin
		rd_value = rd_q[2*DATA_W-1:DATA_W];
		rd_time  = rd_q[DATA_W-1:0];
		high     = |(rd_value & mask_q);
		closing  = high && was_low_q && seen_rise_q;
		opening  = high && was_low_q && !seen_rise_q;
		per      = open_q - rd_time;
		hi_raw   = open_q - fall_q;
		hi_sat   = (hi_raw > per) ? per : hi_raw;
		need_div = closing && duty_q && (per != '0);
		walk_end = (idx_q == count_q);
		avg      = duty_q ? div_rsp.quotient[Q_SHIFT +: DATA_W] : div_rsp.quotient[DATA_W-1:0];
	end

	// record decision
	always_comb begin
		full    = (count_q >= CNT_W'(DEPTH));
		is_meas = (command == CMD_PERIOD) || (command == CMD_DUTY);
		accept  = cmd_valid && cmd_ready;
		rec_ok  = 1'b1;
		wr_en   = 1'b0;
		case (command)
			CMD_RECORD: begin
				rec_ok = !full;
				wr_en  = accept && !full;
			end
			CMD_RECORD_CHG: begin
				rec_ok = !full;
				wr_en  = accept && !full && ((count_q == '0) || (sample_value != last_q));
			end
			default: begin
				rec_ok = 1'b1;
				wr_en  = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_meas) state_d = ST_READ;
			end
			ST_READ: begin
				if (!walk_end) state_d = ST_EVAL;
				else if (n_q == '0) state_d = ST_FINISH;
				else state_d = ST_AVG_GO;
			end
			ST_EVAL: begin
				state_d = need_div ? ST_MUL : ST_READ;
			end
			ST_MUL:        state_d = ST_RATIO_GO;
			ST_RATIO_GO:   state_d = ST_RATIO_WAIT;
			ST_RATIO_WAIT: begin
				if (div_rsp.done) state_d = ST_READ;
			end
			ST_AVG_GO:     state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (div_rsp.done) state_d = ST_FINISH;
			end
			ST_FINISH:     state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready        = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
		mem_rd           = (state_q == ST_READ) && !walk_end;
		div_req.start    = (state_q == ST_RATIO_GO) || (state_q == ST_AVG_GO);
		div_req.dividend = (state_q == ST_AVG_GO) ? acc_q : prod_q;
		div_req.divisor  = (state_q == ST_AVG_GO) ? DSR_W'(n_q) : per_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) count_q <= count_q + 1'b1;
			if (accept && (command == CMD_CLEAR)) count_q <= '0;
			if ((accept && !is_meas) || (state_q == ST_FINISH)) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[ADDR_W-1:0]] <= {sample_value, timestamp};
	end

	always_ff @(posedge clk) begin
		if (mem_rd) rd_q <= mem[idx_q[ADDR_W-1:0]];
	end

	// walk datapath and result payload
	always_ff @(posedge clk) begin
		if (wr_en) last_q <= sample_value;
		if (accept && !is_meas) begin
			ok_q       <= rec_ok;
			measured_q <= '0;
		end
		if (accept && is_meas) begin
			idx_q       <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			open_q      <= '0;
			fall_q      <= '0;
			seen_rise_q <= 1'b0;
			was_low_q   <= 1'b0;
			mask_q      <= bit_mask;
			duty_q      <= (command == CMD_DUTY);
		end
		if (state_q == ST_EVAL) begin
			idx_q <= idx_q + 1'b1;
			if (closing) begin
				n_q       <= n_q + 1'b1;
				open_q    <= rd_time;
				was_low_q <= 1'b0;
				hi_q      <= hi_sat;
				per_q     <= per;
				if (!duty_q) acc_q <= acc_q + DVD_W'(per);
			end else if (opening) begin
				open_q      <= rd_time;
				seen_rise_q <= 1'b1;
				was_low_q   <= 1'b0;
			end else if (!high) begin
				if (!was_low_q) fall_q <= rd_time;
				was_low_q <= 1'b1;
			end
		end
		if (state_q == ST_MUL) prod_q <= DVD_W'(hi_q) * DVD_W'(DUTY_SCALE);
		if ((state_q == ST_RATIO_WAIT) && div_rsp.done) acc_q <= acc_q + div_rsp.quotient;
		if (state_q == ST_FINISH) begin
			ok_q       <= 1'b1;
			measured_q <= (n_q == '0) ? '0 : avg;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign ok        = ok_q;
	assign measured  = measured_q;

	`TCPD_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "entry count beyond depth")
	`TCPD_NEVER(a_idx_range, (state_q != ST_IDLE) && (idx_q > count_q), "walk index past count")
	`TCPD_ASSERT(a_busy_no_rsp, (state_q != ST_IDLE) |-> !rsp_valid_q, "result pending during walk")
	`TCPD_ASSERT(a_div_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
	`TCPD_ASSERT(a_meas_start, (accept && is_meas) |=> (state_q == ST_READ), "walk did not start")

endmodule

// ===== rtl/core/tcpd_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tcpd_pkg and the assertion macro header.
`include "timestamped_capture_period_duty_macros.svh"

module tcpd_div
	import tcpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0]     quo_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DSR_W:0]       shifted;
	logic                 ge;
	logic [DSR_W-1:0]     next_rem;

	always_comb begin
		shifted  = {rem_q, quo_q[DVD_W-1]};
		ge       = shifted >= {1'b0, dsr_q};
		next_rem = ge ? DSR_W'(shifted - {1'b0, dsr_q}) : shifted[DSR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= next_rem;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`TCPD_ASSERT(a_done_not_busy, done_q |-> !busy_q, "divider done while busy")
	`TCPD_ASSERT(a_start_busy, req.start |=> busy_q, "divider did not start")
	`TCPD_ASSERT(a_fall_done, $fell(busy_q) |-> done_q, "divider stopped without done")

endmodule
